// ===== hw/rtl/gsntm_pkg.sv =====
`timescale 1ns / 1ps

package gsntm_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int SAMPLE_LEVELS = 256;

    localparam int VAL_W    = 18;
    localparam int CODE_W   = 12;
    localparam int NIB_W    = 4;
    localparam int ENTRY_W  = VAL_W + CODE_W;
    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 20;
    localparam int COUNT_W  = 13;
    localparam int GAINED_W = 21;
    localparam int DIFF_W   = GAINED_W + 1;
    localparam int POS_W    = ADDR_W + 2;

    // |sample * gain| < 2^27; the quotient by 255 stays below 2^20
    localparam int PROD_W      = SAMPLE_W + 1 + COEF_W;
    localparam int MAG_W       = 27;
    localparam int QUO_W       = 20;
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 24;
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / (SAMPLE_LEVELS - 1);
    localparam int RPROD_W     = MAG_W + RECIP_W;
    localparam int DIVISOR     = SAMPLE_LEVELS - 1;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_START,
        ST_SRCH,
        ST_NBR,
        ST_OUT
    } gsntm_state_t;

    typedef struct packed {
        logic                       valid;
        logic signed [GAINED_W-1:0] level;
    } gsntm_gain_t;

    typedef struct packed {
        logic idle;
        logic done;
    } gsntm_stat_t;

endpackage

// ===== hw/rtl/gained_sample_nearest_table_match.sv =====
`timescale 1ns / 1ps

// Nearest-level lookup for gained samples.
// Input stream (s_*): one word per request. s_tuser selects the kind: a load
// writes load_value/load_code at load_index into the level table, a query
// scales sample by gain/255, adds offset and looks up the nearest entry.
// Output stream (m_*): one word per query, none per load.
// Config port: cfg_we writes cfg_wdata into register cfg_index
// (0 entry count, 1 gain, 2 offset); write only while the block is idle.
// A query passes through the scaling stages (multiply, reciprocal multiply,
// correction, offset), a state issuing the first read, S binary-search steps
// (up to 12 for 4096 entries), W = 1..3 neighbor checks and the output
// register; the table's single read port returns one entry per cycle. One
// query is in flight at a time; the next request is taken once the result is
// registered.
// Reset clears control and loads an entry count of 16, gain 1.0, offset 0;
// table contents are undefined until loaded. A finished result sits in the
// output register while the next request is accepted; a stalled receiver only
// holds up a query at its final hand-off.
module gained_sample_nearest_table_match import gsntm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_index, load_value, load_code, sample, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // found_index, code_a, code_b, code_c, found_value, gained_value, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_wdata
);

    logic [COUNT_W-1:0]      count_reg;
    logic signed [COEF_W-1:0] gain_reg, offset_reg;

    logic                    in_acc, load_we, query_go, out_free;
    gsntm_gain_t             gain_res;
    gsntm_stat_t             stat;
    logic [ADDR_W-1:0]       rd_addr, res_index;
    logic [ENTRY_W-1:0]      rd_data, res_entry;
    logic signed [GAINED_W-1:0] res_level;

    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    assign s_tready = stat.idle;
    assign in_acc   = s_tvalid && s_tready;
    assign load_we  = in_acc && (s_tuser == REQ_LOAD);
    assign query_go = in_acc && (s_tuser == REQ_QUERY);
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= COUNT_W'(16);
            gain_reg   <= COEF_W'(65536);
            offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENTRY_COUNT: count_reg  <= cfg_wdata[COUNT_W-1:0];
                REG_GAIN:        gain_reg   <= cfg_wdata;
                REG_OFFSET:      offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gsntm_table u_table (
        .aclk    (aclk),
        .we      (load_we),
        .wr_addr (s_tdata[ADDR_W-1:0]),
        .wr_data ({s_tdata[29:12], s_tdata[41:30]}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gsntm_gain u_gain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (query_go),
        .sample  (s_tdata[49:42]),
        .gain    (gain_reg),
        .offset  (offset_reg),
        .res     (gain_res)
    );

    gsntm_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (query_go),
        .gain_res    (gain_res),
        .entry_count (count_reg),
        .out_free    (out_free),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .stat        (stat),
        .res_index   (res_index),
        .res_entry   (res_entry),
        .res_level   (res_level)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.done) begin
            m_data_reg <= {1'b0, res_level, res_entry[ENTRY_W-1:CODE_W],
                           res_entry[NIB_W-1:0], res_entry[2*NIB_W-1:NIB_W],
                           res_entry[3*NIB_W-1:2*NIB_W], res_index};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/gsntm_table.sv =====
`timescale 1ns / 1ps

module gsntm_table import gsntm_pkg::*; (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/gsntm_gain.sv =====
`timescale 1ns / 1ps

module gsntm_gain import gsntm_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [SAMPLE_W-1:0]      sample,
    input  logic signed [COEF_W-1:0] gain,
    input  logic signed [COEF_W-1:0] offset,
    output gsntm_gain_t              res
);

    logic [3:0] valid_reg;

    logic signed [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0]        pmag_c;
    logic [MAG_W-1:0]         mag1_reg, mag2_reg;
    logic                     neg1_reg, neg2_reg, neg3_reg;
    logic [RPROD_W-1:0]       rprod_c;
    logic [QUO_W-1:0]         q2_reg, q3_reg;
    logic [MAG_W:0]           qx_c, rem_c;
    logic                     ge_c, rnz_c, rnz3_reg;
    logic [QUO_W:0]           qup_c;
    logic [DIFF_W-1:0]        sum_c;
    logic signed [GAINED_W-1:0] level_reg;

    assign prod_c  = $signed({1'b0, sample}) * gain;
    assign pmag_c  = prod_c[PROD_W-1] ? PROD_W'(-prod_c) : PROD_W'(prod_c);
    assign rprod_c = RPROD_W'(mag1_reg) * RPROD_W'(RECIP[RECIP_W-1:0]);

    // estimate is low by at most one; fix with a single compare
    assign qx_c  = {q2_reg, 8'd0} - {{(MAG_W + 1 - QUO_W){1'b0}}, q2_reg};
    assign rem_c = {1'b0, mag2_reg} - qx_c;
    assign ge_c  = rem_c >= (MAG_W + 1)'(DIVISOR);
    assign rnz_c = ge_c ? (rem_c != (MAG_W + 1)'(DIVISOR)) : (rem_c != '0);

    // floor toward minus infinity: negative side rounds magnitude up
    assign qup_c = {1'b0, q3_reg} + {{QUO_W{1'b0}}, rnz3_reg};
    assign sum_c = neg3_reg
        ? DIFF_W'(offset) - {{(DIFF_W - QUO_W - 1){1'b0}}, qup_c}
        : DIFF_W'(offset) + {{(DIFF_W - QUO_W){1'b0}}, q3_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[2:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        mag1_reg  <= pmag_c[MAG_W-1:0];
        neg1_reg  <= prod_c[PROD_W-1];
        q2_reg    <= rprod_c[RECIP_SHIFT +: QUO_W];
        mag2_reg  <= mag1_reg;
        neg2_reg  <= neg1_reg;
        q3_reg    <= q2_reg + {{(QUO_W - 1){1'b0}}, ge_c};
        rnz3_reg  <= rnz_c;
        neg3_reg  <= neg2_reg;
        level_reg <= sum_c[GAINED_W-1:0];
    end

    assign res.valid = valid_reg[3];
    assign res.level = level_reg;

endmodule

// ===== hw/rtl/gsntm_search.sv =====
`timescale 1ns / 1ps

module gsntm_search import gsntm_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       go,
    input  gsntm_gain_t                gain_res,
    input  logic [COUNT_W-1:0]         entry_count,
    input  logic                       out_free,
    output logic [ADDR_W-1:0]          rd_addr,
    input  logic [ENTRY_W-1:0]         rd_data,
    output gsntm_stat_t                stat,
    output logic [ADDR_W-1:0]          res_index,
    output logic [ENTRY_W-1:0]         res_entry,
    output logic signed [GAINED_W-1:0] res_level
);

    gsntm_state_t state_reg, state_next;

    logic signed [GAINED_W-1:0] g_reg, g_next;
    logic [ADDR_W-1:0]          nm1_reg, nm1_next;
    logic signed [POS_W-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [ADDR_W-1:0]          mid_reg, mid_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next, last_reg, last_next;
    logic                       have_reg, have_next;
    logic [DIFF_W-1:0]          best_reg, best_next;
    logic [ADDR_W-1:0]          pick_reg, pick_next;
    logic [ENTRY_W-1:0]         entry_reg, entry_next;

    logic [ADDR_W-1:0]       nm1_c;
    logic [DIFF_W-1:0]       diff_c, abs_c;
    logic                    d_neg, d_zero;
    logic signed [POS_W-1:0] mid_pos, lo_n, hi_n, sum_n;
    logic [ADDR_W-1:0]       mid_n;
    logic                    srch_exit, better, nbr_end;
    logic [ADDR_W-1:0]       nbr_mid, nbr_nm1, first_c, last_c;

    // clamp count to 1..TABLE_DEPTH, keep count-1
    always_comb begin
        if (entry_count == '0) begin
            nm1_c = '0;
        end else if (entry_count > COUNT_W'(TABLE_DEPTH)) begin
            nm1_c = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            nm1_c = ADDR_W'(entry_count - 1'b1);
        end
    end

    assign diff_c = {{(DIFF_W - VAL_W){1'b0}}, rd_data[ENTRY_W-1:CODE_W]}
                  - {g_reg[GAINED_W-1], g_reg};
    assign d_neg  = diff_c[DIFF_W-1];
    assign d_zero = (diff_c == '0);
    assign abs_c  = d_neg ? (~diff_c + 1'b1) : diff_c;

    assign mid_pos   = $signed({2'b00, mid_reg});
    assign lo_n      = d_neg ? mid_pos + POS_W'(1) : lo_reg;
    assign hi_n      = (!d_neg && !d_zero) ? mid_pos - POS_W'(1) : hi_reg;
    assign srch_exit = d_zero || !(lo_n < hi_n);
    assign sum_n     = lo_n + hi_n;
    assign mid_n     = sum_n[ADDR_W:1];

    assign better  = !have_reg || (abs_c < best_reg);
    assign nbr_end = (idx_reg == last_reg);

    // neighbor window around the final midpoint
    assign nbr_mid = (state_reg == ST_START) ? '0 : mid_reg;
    assign nbr_nm1 = (state_reg == ST_START) ? nm1_c : nm1_reg;
    assign first_c = (nbr_mid == '0) ? '0 : nbr_mid - 1'b1;
    assign last_c  = (nbr_mid == nbr_nm1) ? nbr_mid : nbr_mid + 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (gain_res.valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = (nm1_c == '0) ? ST_NBR : ST_SRCH;
            end
            ST_SRCH: begin
                if (srch_exit) begin
                    state_next = ST_NBR;
                end
            end
            ST_NBR: begin
                if (nbr_end) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        g_next     = g_reg;
        nm1_next   = nm1_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        have_next  = have_reg;
        best_next  = best_reg;
        pick_next  = pick_reg;
        entry_next = entry_reg;
        rd_addr    = mid_reg;
        stat.idle  = 1'b0;
        stat.done  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                stat.idle = 1'b1;
            end
            ST_GAIN: begin
                if (gain_res.valid) begin
                    g_next = gain_res.level;
                end
            end
            ST_START: begin
                nm1_next = nm1_c;
                if (nm1_c == '0) begin
                    mid_next  = '0;
                    idx_next  = first_c;
                    last_next = last_c;
                    have_next = 1'b0;
                    rd_addr   = first_c;
                end else begin
                    lo_next  = '0;
                    hi_next  = $signed({2'b00, nm1_c});
                    mid_next = nm1_c >> 1;
                    rd_addr  = nm1_c >> 1;
                end
            end
            ST_SRCH: begin
                lo_next = lo_n;
                hi_next = hi_n;
                if (srch_exit) begin
                    idx_next  = first_c;
                    last_next = last_c;
                    have_next = 1'b0;
                    rd_addr   = first_c;
                end else begin
                    mid_next = mid_n;
                    rd_addr  = mid_n;
                end
            end
            ST_NBR: begin
                if (better) begin
                    have_next  = 1'b1;
                    best_next  = abs_c;
                    pick_next  = idx_reg;
                    entry_next = rd_data;
                end
                if (!nbr_end) begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            ST_OUT: begin
                stat.done = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        g_reg     <= g_next;
        nm1_reg   <= nm1_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        have_reg  <= have_next;
        best_reg  <= best_next;
        pick_reg  <= pick_next;
        entry_reg <= entry_next;
    end

    assign res_index = pick_reg;
    assign res_entry = entry_reg;
    assign res_level = g_reg;

endmodule

// ===== hw/rtl/gsntm_checker.sv =====
`timescale 1ns / 1ps

module gsntm_checker import gsntm_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    // a load never produces a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("output word after a load");

    // one query in flight: busy right after a query is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_QUERY) |=> !s_tready)
        else $error("request taken while a query is in flight");

endmodule

bind gained_sample_nearest_table_match gsntm_checker u_checker (.*);
